@@ sv/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg: shared constants and types for the ray/sphere intersect pipeline
// widths of the exact fixed point datapath and the sideband structs
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int COORD_W       = 32;  // coordinate and direction width
	localparam int LW            = 33;  // origin minus center
	localparam int AW            = 64;  // a = dir.dir
	localparam int MW            = 68;  // h and c, signed, and their magnitudes
	localparam int PW            = 2 * MW;  // product width
	localparam int DW            = PW + 2;  // discriminant, signed
	localparam int RTW           = DW / 2;  // square root width
	localparam int NW            = 70;  // root numerator and denominator width
	localparam int DIST_W        = 32;  // distance width
	localparam int RSQ_W         = 63;  // radius squared width
	localparam int CFG_IDX_W     = 8;
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X   = 8'd0,
		REG_CENTER_Y   = 8'd1,
		REG_CENTER_Z   = 8'd2,
		REG_RADIUS_SQR = 8'd3
	} cfg_reg_t;

	// sideband that travels next to the discriminant through the root unit
	typedef struct packed {
		logic [AW-1:0] a;
		logic [MW-1:0] habs;
		logic          hpos;
		logic [MW-1:0] cabs;
		logic          csign;
		logic          miss;
		logic          dzero;
	} sq_side_t;

	// sideband that travels next to the near root through its divider
	typedef struct packed {
		logic miss;
		logic dzero;
		logic neg0;
	} dv_side_t;

endpackage

@@ sv/ray_sphere_intersect.sv @@
// throughput: one item per cycle; the whole pipeline moves together and holds
//   only while the output register is full and not taken
// stage count is set by the root unit (69 stages) and the two dividers (33 each)
// reset: arst_n clears valid bits and the sphere registers to zero
// ----------------------------------------------------------------------------
// ray_sphere_intersect: ray against sphere, exact fixed point quadratic
// L = o - c, a = d.d, h = d.L, c = L.L - r2, D = h*h - a*c, stable roots
// ----------------------------------------------------------------------------
module ray_sphere_intersect import rsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RSQ_W-1:0]     cfg_data,
	// ray items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [COORD_W-1:0]   origin_x,
	input  logic [COORD_W-1:0]   origin_y,
	input  logic [COORD_W-1:0]   origin_z,
	input  logic [COORD_W-1:0]   dir_x,
	input  logic [COORD_W-1:0]   dir_y,
	input  logic [COORD_W-1:0]   dir_z,
	// result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [DIST_W-1:0]    hit_distance
);

	// sphere registers
	logic [COORD_W-1:0] center_q [3];
	logic [RSQ_W-1:0]   rsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			rsq_q       <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:   center_q[0] <= cfg_data[COORD_W-1:0];
				REG_CENTER_Y:   center_q[1] <= cfg_data[COORD_W-1:0];
				REG_CENTER_Z:   center_q[2] <= cfg_data[COORD_W-1:0];
				REG_RADIUS_SQR: rsq_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: every stage moves when the output register can take
	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	logic [COORD_W-1:0] org [3];
	logic [COORD_W-1:0] dir [3];

	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	// s1: L = origin - center
	logic signed [LW-1:0]      l_s1 [3];
	logic signed [COORD_W-1:0] d_s1 [3];
	logic                      vld_s1;

	// s2: per axis products
	logic signed [AW-1:0]   dd_s2 [3];
	logic signed [AW:0]     dl_s2 [3];
	logic signed [AW+1:0]   ll_s2 [3];
	logic                   vld_s2;

	// s3: a, h, c
	logic [AW-1:0]        a_s3;
	logic signed [MW-1:0] h_s3;
	logic signed [MW-1:0] c_s3;
	logic                 vld_s3;

	// s4: magnitudes into the multipliers, s5/s6 ride along with them
	sq_side_t side_s4, side_s5, side_s6, side_s7;
	logic     vld_s4, vld_s5, vld_s6, vld_s7;

	logic [PW-1:0] hh_prod, ac_prod;
	logic [DW-1:0] d_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				l_s1[i]  <= $signed({org[i][COORD_W-1], org[i]})
					- $signed({center_q[i][COORD_W-1], center_q[i]});
				d_s1[i]  <= $signed(dir[i]);
				dd_s2[i] <= d_s1[i] * d_s1[i];
				dl_s2[i] <= d_s1[i] * l_s1[i];
				ll_s2[i] <= l_s1[i] * l_s1[i];
			end
			// squares are never negative, so the low bits are the value
			a_s3 <= AW'(dd_s2[0]) + AW'(dd_s2[1]) + AW'(dd_s2[2]);
			h_s3 <= MW'(dl_s2[0]) + MW'(dl_s2[1]) + MW'(dl_s2[2]);
			c_s3 <= MW'(ll_s2[0]) + MW'(ll_s2[1]) + MW'(ll_s2[2]) - MW'(rsq_q);

			side_s4.a     <= a_s3;
			side_s4.habs  <= h_s3[MW-1] ? MW'(-h_s3) : MW'(h_s3);
			side_s4.hpos  <= !h_s3[MW-1] && (h_s3 != '0);
			side_s4.cabs  <= c_s3[MW-1] ? MW'(-c_s3) : MW'(c_s3);
			side_s4.csign <= c_s3[MW-1];
			side_s4.miss  <= a_s3 == '0;  // zero direction
			side_s4.dzero <= 1'b0;

			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
			// D = h*h - a*c, c carried as sign and magnitude
			d_s7 <= side_s6.csign ? DW'(hh_prod) + DW'(ac_prod)
				: DW'(hh_prod) - DW'(ac_prod);
		end
	end

	rsi_mul #(.W(MW)) u_mul_hh (
		.clk  (clk),
		.en   (en),
		.op_a (side_s4.habs),
		.op_b (side_s4.habs),
		.prod (hh_prod)
	);

	rsi_mul #(.W(MW)) u_mul_ac (
		.clk  (clk),
		.en   (en),
		.op_a (MW'(side_s4.a)),
		.op_b (side_s4.cabs),
		.prod (ac_prod)
	);

	// root unit: negative discriminant is a miss and takes a zero radicand
	sq_side_t      sq_in, sq_out;
	logic [DW-1:0] rad;
	logic [RTW-1:0] s_root;
	logic           vld_sq;
	logic [$bits(sq_side_t)-1:0] sq_out_vec;

	always_comb begin
		sq_in       = side_s7;
		sq_in.miss  = side_s7.miss || d_s7[DW-1];
		sq_in.dzero = d_s7 == '0;
		rad         = d_s7[DW-1] ? '0 : d_s7;
	end

	rsi_sqrt #(.RW(DW), .SW($bits(sq_side_t))) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s7),
		.rad      (rad),
		.side_in  (sq_in),
		.out_vld  (vld_sq),
		.root     (s_root),
		.side_out (sq_out_vec)
	);

	assign sq_out = sq_out_vec;

	// s9: |q| = |h| + s; q is negative exactly when h is positive
	logic [NW-1:0] qabs_s9, a_s9, cabs_s9;
	logic          neg1_s9;
	dv_side_t      dv_s9;
	logic          vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qabs_s9     <= NW'(sq_out.habs) + NW'(s_root);
			a_s9        <= NW'(sq_out.a);
			cabs_s9     <= NW'(sq_out.cabs);
			neg1_s9     <= (sq_out.csign != sq_out.hpos) && (sq_out.cabs != '0);
			dv_s9.miss  <= sq_out.miss;
			dv_s9.dzero <= sq_out.dzero;
			dv_s9.neg0  <= sq_out.hpos;
		end
	end

	// near root q/a and far root c/q
	logic [DIST_W-1:0] m0, m1;
	logic              vld_d0, vld_d1;
	logic [$bits(dv_side_t)-1:0] dv_out_vec;
	dv_side_t          dv_out;
	logic              neg1;

	rsi_div #(.NW_P(NW), .QW(DIST_W), .FRAC_BITS(FRAC_BITS), .SW($bits(dv_side_t))) u_div0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s9),
		.num      (qabs_s9),
		.den      (a_s9),
		.side_in  (dv_s9),
		.out_vld  (vld_d0),
		.quo      (m0),
		.side_out (dv_out_vec)
	);

	rsi_div #(.NW_P(NW), .QW(DIST_W), .FRAC_BITS(FRAC_BITS), .SW(1)) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s9),
		.num      (cabs_s9),
		.den      (qabs_s9),
		.side_in  (neg1_s9),
		.out_vld  (vld_d1),
		.quo      (m1),
		.side_out (neg1)
	);

	assign dv_out = dv_out_vec;

	// pick the smallest root that is not negative; with a double root only
	// the near root counts
	logic hit0, hit1, pick1;
	logic hit_q;
	logic [DIST_W-1:0] dist_q;

	always_comb begin
		hit0  = !dv_out.miss && !dv_out.neg0;
		hit1  = !dv_out.miss && !dv_out.dzero && !neg1;
		pick1 = hit1 && (!hit0 || (m1 < m0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_d0 && vld_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= hit0 || hit1;
			dist_q <= pick1 ? m1 : (hit0 ? m0 : '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign hit_distance = dist_q;

`ifndef NO_ASSERTIONS
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		vld_d0 == vld_d1)
		else $error("divider valid bits out of step");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_distance == '0)
		else $error("miss item with nonzero distance");

	a_hold_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid && $stable(hit_distance) && $stable(hit))
		else $error("output changed while pipeline held");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while output stalled");
`endif

endmodule

@@ sv/rsi_mul.sv @@
// ----------------------------------------------------------------------------
// rsi_mul: wide unsigned multiplier
// split in half-width partial products, summed in a second stage
// ----------------------------------------------------------------------------
module rsi_mul import rsi_pkg::*; #(
	parameter int W = MW
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   op_a,
	input  logic [W-1:0]   op_b,
	output logic [2*W-1:0] prod
);

	localparam int HL = W / 2;
	localparam int HH = W - HL;

	logic [2*HL-1:0]    ll_s1;
	logic [HL+HH-1:0]   lh_s1;
	logic [HL+HH-1:0]   hl_s1;
	logic [2*HH-1:0]    hh_s1;
	logic [2*W-1:0]     prod_s2;
	logic [2*W-1:0]     mid;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= op_a[HL-1:0] * op_b[HL-1:0];
			lh_s1 <= op_a[HL-1:0] * op_b[W-1:HL];
			hl_s1 <= op_a[W-1:HL] * op_b[HL-1:0];
			hh_s1 <= op_a[W-1:HL] * op_b[W-1:HL];
		end
	end

	assign mid = (2*W)'(lh_s1) + (2*W)'(hl_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= {hh_s1, ll_s1} + (mid << HL);
		end
	end

	assign prod = prod_s2;

endmodule

@@ sv/rsi_sqrt.sv @@
// ----------------------------------------------------------------------------
// rsi_sqrt: pipelined integer square root
// one result bit per stage, floor of the root
// ----------------------------------------------------------------------------
module rsi_sqrt import rsi_pkg::*; #(
	parameter int RW = DW,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [RW-1:0]   rad,
	input  logic [SW-1:0]   side_in,
	output logic            out_vld,
	output logic [RW/2-1:0] root,
	output logic [SW-1:0]   side_out
);

	localparam int N = RW / 2;

	logic [RW-1:0] rad_s  [N];
	logic [N+1:0]  rem_s  [N];
	logic [N-1:0]  root_s [N];
	logic [SW-1:0] side_s [N];
	logic          vld_s  [N];

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_stage
			logic [RW-1:0] rad_i;
			logic [N+1:0]  rem_i;
			logic [N-1:0]  root_i;
			logic [SW-1:0] side_i;
			logic          vld_i;
			logic [N+1:0]  rem_sh;
			logic [N+1:0]  trial;
			logic          take;

			if (g == 0) begin : g_src
				assign rad_i  = rad;
				assign rem_i  = '0;
				assign root_i = '0;
				assign side_i = side_in;
				assign vld_i  = in_vld;
			end else begin : g_src
				assign rad_i  = rad_s[g-1];
				assign rem_i  = rem_s[g-1];
				assign root_i = root_s[g-1];
				assign side_i = side_s[g-1];
				assign vld_i  = vld_s[g-1];
			end

			// bring down two radicand bits, try root*4+1
			assign rem_sh = {rem_i[N-1:0], rad_i[RW-1 -: 2]};
			assign trial  = {root_i, 2'b01};
			assign take   = rem_sh >= trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (en) begin
					vld_s[g] <= vld_i;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[g]  <= rad_i << 2;
					rem_s[g]  <= take ? rem_sh - trial : rem_sh;
					root_s[g] <= {root_i[N-2:0], take};
					side_s[g] <= side_i;
				end
			end
		end
	endgenerate

	assign out_vld  = vld_s[N-1];
	assign root     = root_s[N-1];
	assign side_out = side_s[N-1];

endmodule

@@ sv/rsi_div.sv @@
// ----------------------------------------------------------------------------
// rsi_div: pipelined fixed point divider
// quotient floor(num * 2^frac / den), saturated to the quotient width
// ----------------------------------------------------------------------------
module rsi_div import rsi_pkg::*; #(
	parameter int NW_P      = NW,
	parameter int QW        = DIST_W,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SW        = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [NW_P-1:0] num,
	input  logic [NW_P-1:0] den,
	input  logic [SW-1:0]   side_in,
	output logic            out_vld,
	output logic [QW-1:0]   quo,
	output logic [SW-1:0]   side_out
);

	localparam int RMW = NW_P + QW;

	logic [RMW-1:0]  rem_s  [QW+1];
	logic [NW_P-1:0] den_s  [QW+1];
	logic [QW-1:0]   q_s    [QW+1];
	logic            sat_s  [QW+1];
	logic [SW-1:0]   side_s [QW+1];
	logic            vld_s  [QW+1];

	logic [RMW-1:0] num_sh;
	logic [RMW-1:0] den_top;

	assign num_sh  = RMW'(num) << FRAC_BITS;
	assign den_top = RMW'(den) << QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	// quotient too large for the output: saturate
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num_sh;
			den_s[0]  <= den;
			q_s[0]    <= '0;
			sat_s[0]  <= num_sh >= den_top;
			side_s[0] <= side_in;
		end
	end

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_step
			localparam int B = QW - 1 - k;
			logic [RMW-1:0] trial;
			logic           take;

			assign trial = RMW'(den_s[k]) << B;
			assign take  = rem_s[k] >= trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k+1] <= 1'b0;
				end else if (en) begin
					vld_s[k+1] <= vld_s[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1]  <= take ? rem_s[k] - trial : rem_s[k];
					den_s[k+1]  <= den_s[k];
					q_s[k+1]    <= q_s[k] | (take ? (QW'(1) << B) : '0);
					sat_s[k+1]  <= sat_s[k];
					side_s[k+1] <= side_s[k];
				end
			end
		end
	endgenerate

	assign out_vld  = vld_s[QW];
	assign quo      = sat_s[QW] ? '1 : q_s[QW];
	assign side_out = side_s[QW];

endmodule

@@ tb/sv/tb_ray_sphere_intersect.sv @@
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect: regression bench for the ray/sphere intersect block
// streams rays through the pipeline under random stalls on both sides and
// checks every hit flag and distance against an exact wide-integer predictor
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersect;
	import rsi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd4;  // past the last register
	localparam int LATENCY     = 111;
	localparam int CYCLE_LIMIT = 600000;
	localparam int IDLE_PCT    = 22;
	localparam int ONE         = 65536;  // 1.0 in Q16.16

	typedef struct packed {
		logic [2:0][COORD_W-1:0] org;
		logic [2:0][COORD_W-1:0] dir;
	} ray_t;

	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] distance;
	} hit_t;

	typedef logic signed [191:0] wide_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RSQ_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [COORD_W-1:0]   origin_x = '0, origin_y = '0, origin_z = '0;
	logic [COORD_W-1:0]   dir_x = '0, dir_y = '0, dir_z = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 hit;
	logic [DIST_W-1:0]    hit_distance;

	ray_t ray_queue[$];   // rays waiting for the driver
	hit_t hit_queue[$];   // predicted results, oldest first
	ray_t ray_cur;
	logic ray_taken = 1'b0;
	logic steady = 1'b0;  // no idling on either side while set
	int   errors = 0, n_results = 0, n_hits = 0, n_rays = 0, n_cfg = 0;
	int   cycles = 0;

	// predictor's copy of the sphere registers
	logic [2:0][COORD_W-1:0] sph_center = '0;
	logic [RSQ_W-1:0]        sph_rsq = '0;

	ray_sphere_intersect dut (
		.clk, .arst_n, .cfg_wen, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .origin_x, .origin_y, .origin_z, .dir_x, .dir_y, .dir_z,
		.out_valid, .out_ready, .hit, .hit_distance
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// floor square root, bit by bit
	function automatic wide_t floor_sqrt(wide_t v);
		wide_t res, bitv, t;
		res = 0;
		bitv = wide_t'(1) <<< 190;
		while (bitv != 0 && bitv > v) bitv = bitv >>> 2;
		while (bitv != 0) begin
			t = res + bitv;
			if (v >= t) begin
				v = v - t;
				res = (res >>> 1) + bitv;
			end else begin
				res = res >>> 1;
			end
			bitv = bitv >>> 2;
		end
		return res;
	endfunction

	// one root num/den: exact sign, truncated saturated magnitude
	function automatic logic [DIST_W-1:0] root_mag(wide_t num, wide_t den, output logic neg);
		wide_t an, ad, q;
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		neg = ((num < 0) != (den < 0)) && (an != 0);
		q = (an <<< 16) / ad;
		if (q > 192'sh0FFFFFFFF) return '1;
		return q[DIST_W-1:0];
	endfunction

	function automatic hit_t trace_sphere(ray_t r);
		wide_t a, h, c, disc, s, qv, lv, dv, n0, d0, n1, d1;
		logic neg0, neg1;
		logic [DIST_W-1:0] m0, m1;
		hit_t res;
		a = 0;
		h = 0;
		c = 0;
		c = c - $signed({129'd0, sph_rsq});
		res = '0;
		for (int i = 0; i < 3; i++) begin
			lv = $signed(r.org[i]);
			lv = lv - $signed(sph_center[i]);
			dv = $signed(r.dir[i]);
			a = a + dv * dv;
			h = h + dv * lv;
			c = c + lv * lv;
		end
		if (a == 0) return res;  // zero direction
		disc = h * h - a * c;
		if (disc < 0) return res;
		if (disc == 0) begin
			// tangent: both roots -h/a
			n0 = -h; d0 = a; n1 = -h; d1 = a;
		end else begin
			s = floor_sqrt(disc);
			qv = (h > 0) ? -(h + s) : s - h;
			n0 = qv; d0 = a; n1 = c; d1 = qv;
		end
		m0 = root_mag(n0, d0, neg0);
		m1 = root_mag(n1, d1, neg1);
		if (!neg0) begin
			res.hit = 1'b1;
			res.distance = m0;
		end
		if (!neg1 && (!res.hit || m1 < res.distance)) begin
			res.hit = 1'b1;
			res.distance = m1;
		end
		return res;
	endfunction

	// driver: new item only after the previous one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || ray_taken) begin
				if (ray_queue.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					ray_cur = ray_queue.pop_front();
					{origin_z, origin_y, origin_x} <= ray_cur.org;
					{dir_z, dir_y, dir_x} <= ray_cur.dir;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor: predict on each accepted ray, check each accepted result
	always @(posedge clk) begin
		hit_t want;
		ray_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			hit_queue.push_back(trace_sphere({origin_z, origin_y, origin_x, dir_z, dir_y, dir_x}));
			n_rays++;
		end
		if (out_valid && out_ready) begin
			n_results++;
			if (hit_queue.size() == 0) begin
				$error("result with no ray waiting: hit %0b distance %h", hit, hit_distance);
				errors++;
			end else begin
				want = hit_queue.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0b actual %0b", want.hit, hit);
					errors++;
				end
				if (hit_distance !== want.distance) begin
					$error("hit_distance: expected %h actual %h", want.distance, hit_distance);
					errors++;
				end
				if (want.hit) n_hits++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, hit_queue.size());
			$display("ray_sphere_intersect regression: fail");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RSQ_W-1:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_CENTER_X: sph_center[0] = val[31:0];
			REG_CENTER_Y: sph_center[1] = val[31:0];
			REG_CENTER_Z: sph_center[2] = val[31:0];
			REG_RADIUS_SQR: sph_rsq = val;
			default: ;  // ignored by the block
		endcase
		n_cfg++;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [RSQ_W-1:0] rsq);
		write_reg(REG_CENTER_X,
			RSQ_W'({$urandom(), $urandom()} & 64'h7FFFFFFF_00000000 | 64'(cx)));
		write_reg(REG_CENTER_Y, RSQ_W'(cy));
		write_reg(REG_CENTER_Z, RSQ_W'(cz));
		write_reg(REG_RADIUS_SQR, rsq);
		write_reg(REG_UNUSED, RSQ_W'({$urandom(), $urandom()}));
	endtask

	// drain the pipeline before touching the registers
	task automatic wait_idle();
		do @(negedge clk);
		while (ray_queue.size() != 0 || in_valid || hit_queue.size() != 0);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic add_ray(int ox, int oy, int oz, int dx, int dy, int dz);
		ray_t r;
		r.org = {oz, oy, ox};
		r.dir = {dz, dy, dx};
		ray_queue.push_back(r);
	endtask

	task automatic directed_rays();
		add_ray(0, 0, -5 * ONE, 0, 0, 0);                 // zero direction
		add_ray(-5 * ONE, 3 * ONE, 0, ONE, 0, 0);         // clean miss
		add_ray(-5 * ONE, ONE, 0, ONE, 0, 0);             // tangent
		add_ray(-5 * ONE, 0, 0, ONE, 0, 0);               // head-on hit
		add_ray(0, 0, 0, 0, ONE, 0);                      // inside, one root negative
		add_ray(5 * ONE, 0, 0, ONE, 0, 0);                // sphere behind
		add_ray(ONE + 1, 0, 0, ONE, 0, 0);                // tiny negative root
		add_ray(ONE, 0, 0, ONE, 0, 0);                    // on the surface leaving
		add_ray(-ONE, 0, 0, ONE, 0, 0);                   // on the surface entering
		add_ray(-5 * ONE, 0, 0, 1, 0, 0);                 // distance saturates
		add_ray(-2 * ONE, 0, 0, 32'sh7FFFFFFF, 0, 0);      // huge direction
		add_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		add_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		add_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		add_ray(-1, -1, -1, -1, -1, -1);
		add_ray(0, 0, 0, 32'sh80000000, 0, 0);
		add_ray(3 * ONE, -4 * ONE, 2 * ONE, -3 * ONE, 4 * ONE, -2 * ONE);
		add_ray(0, 0, 0, 1, 1, 1);
	endtask

	// mostly rays aimed near the sphere, the rest raw noise
	task automatic random_rays(int count);
		ray_t r;
		int sh, pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(9);
			if (pick < 7) begin
				sh = $urandom_range(22, 8);
				for (int i = 0; i < 3; i++) begin
					r.org[i] = sph_center[i] + ($signed($urandom()) >>> (32 - sh));
					r.dir[i] = sph_center[i] + ($signed($urandom()) >>> (32 - sh + 2)) - r.org[i];
					r.dir[i] = $signed(r.dir[i]) >>> $urandom_range(4);
				end
				if ($urandom_range(9) == 0) r.dir = '0;
			end else begin
				for (int i = 0; i < 3; i++) begin
					r.org[i] = $urandom();
					r.dir[i] = $urandom();
				end
			end
			ray_queue.push_back(r);
		end
	endtask

	task automatic random_sphere();
		logic [63:0] rad;
		rad = 64'($urandom_range(22 * ONE, 1));
		set_sphere($signed($urandom()) >>> $urandom_range(16, 8),
			$signed($urandom()) >>> $urandom_range(16, 8),
			$signed($urandom()) >>> $urandom_range(16, 8), RSQ_W'(rad * rad));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: zero center, zero radius
		directed_rays();
		wait_idle();

		// unit sphere at the origin
		set_sphere(0, 0, 0, RSQ_W'(64'd1 << 32));
		directed_rays();
		wait_idle();

		// register extremes
		set_sphere(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, '1);
		directed_rays();
		random_rays(60);
		wait_idle();
		set_sphere(32'h80000000, 32'h7FFFFFFF, 32'h80000000, '0);
		random_rays(60);
		wait_idle();
		set_sphere($urandom(), $urandom(), $urandom(), RSQ_W'({$urandom(), $urandom()}));
		random_rays(60);
		wait_idle();

		// ordinary spheres, one phase with no idling at all
		for (int p = 0; p < 5; p++) begin
			random_sphere();
			steady = (p == 2);
			random_rays(130);
			wait_idle();
		end
		steady = 1'b0;

		$display("covered %0d rays, %0d results (%0d hits), %0d register writes",
			n_rays, n_results, n_hits, n_cfg);
		$display("spheres at reset, unit, extreme and random settings, with stalls on both sides");
		if (errors == 0 && hit_queue.size() == 0) begin
			$display("ray_sphere_intersect regression: pass");
		end else begin
			$display("ray_sphere_intersect regression: fail");
		end
		$finish;
	end

endmodule
